/* rtl/ep2c_pkg.sv */
// Package for the epoch seconds to calendar converter.
// Holds the sequencer state codes, register indexes, time constants and the
// month length table. No dependencies.
package ep2c_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIVD  = 8'b0000_0010,
    S_HOUR  = 8'b0000_0100,
    S_MINS  = 8'b0000_1000,
    S_WDAY  = 8'b0001_0000,
    S_YEAR  = 8'b0010_0000,
    S_MONTH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } ep2c_state_t;

  // Controls for the year tracker.
  typedef struct packed {
    logic init;
    logic step;
  } ep2c_yctl_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ZONE = 2'd0;
  localparam logic [1:0] CFG_DST  = 2'd1;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;
  localparam logic [3:0]  FEBRUARY      = 4'd1;

  // 1970 as offset from 1900, and its residues mod 4, 100 and 400.
  localparam logic [7:0] YEAR_INIT = 8'd70;
  localparam logic [1:0] M4_INIT   = 2'd2;
  localparam logic [6:0] M100_INIT = 7'd70;
  localparam logic [8:0] M400_INIT = 9'd370;
  localparam logic [6:0] M100_LAST = 7'd99;
  localparam logic [8:0] M400_LAST = 9'd399;

  // Weekday of 1970-01-01 (Thursday).
  localparam logic [3:0] WDAY_BASE = 4'd4;
  localparam logic [3:0] DAYS_PER_WEEK = 4'd7;

  // Length of a month in a common year.
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* rtl/ep2c_sub.sv */
// Shared compare-and-subtract unit of the epoch converter.
// Gives a - b and whether a >= b. Uses nothing from the package.
module ep2c_sub #(
  parameter int W = 18
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic borrow;

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
  assign ge = ~borrow;

endmodule

/* rtl/ep2c_yr.sv */
// Year tracker of the epoch converter: year since 1900 and the Gregorian
// leap flag, kept by residue counters. Depends on ep2c_pkg.
module ep2c_yr (
  input  logic                clk,
  input  ep2c_pkg::ep2c_yctl_t ctl,
  output logic [7:0]          year,
  output logic                leap
);
  import ep2c_pkg::*;

  logic [7:0] yr_r,   yr_nxt;
  logic [1:0] m4_r,   m4_nxt;
  logic [6:0] m100_r, m100_nxt;
  logic [8:0] m400_r, m400_nxt;

  always_comb begin
    yr_nxt   = yr_r;
    m4_nxt   = m4_r;
    m100_nxt = m100_r;
    m400_nxt = m400_r;
    if (ctl.init) begin
      yr_nxt   = YEAR_INIT;
      m4_nxt   = M4_INIT;
      m100_nxt = M100_INIT;
      m400_nxt = M400_INIT;
    end else if (ctl.step) begin
      // The year since 1900 keeps only its low eight bits.
      yr_nxt   = yr_r + 8'd1;
      m4_nxt   = m4_r + 2'd1;
      m100_nxt = (m100_r == M100_LAST) ? 7'd0 : m100_r + 7'd1;
      m400_nxt = (m400_r == M400_LAST) ? 9'd0 : m400_r + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    yr_r   <= yr_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
  end

  assign year = yr_r;
  assign leap = (m4_r == 2'd0) && ((m100_r != 7'd0) || (m400_r == 9'd0));

endmodule

/* rtl/epoch_seconds_to_calendar_unit.sv */
// Epoch seconds to calendar time. Each transfer on the input channel carries
// Unix seconds; the block subtracts the configured zone offset (seconds west
// of UTC), adds one hour when daylight time is on, clamps the result to
// 0 .. 2^EPOCH_BITS-1 and delivers one broken-down calendar time per input.
// Each result is produced step by step from its input: EPOCH_BITS steps of
// long division by 86400, 5 and 6 steps to split the seconds of the day into
// hours and minutes, EPOCH_BITS-16 steps to reduce the day count mod 7, one
// step per year elapsed since 1970 and per month index plus one more step
// each that finds the year and the month, and a last step that loads the
// output register once the result channel has room. The arithmetic steps
// share a single compare-and-subtract unit driven by a one-hot sequencer, so
// at 32 bits the slowest input is one in December 2105, as the clamped range
// ends in February 2106. in_stall is high from the cycle after an input
// transfer until the sequencer is back to idle; a finished result waits in
// the output register while the next input is taken. Configuration writes
// are always accepted (cfg_ready is tied high) and must only be made while
// the block is idle; writes to an index beyond the two registers are ignored.
module epoch_seconds_to_calendar_unit #(
  parameter int EPOCH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_epoch_time,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_second_of_minute,
  output logic [5:0]  out_minute_of_hour,
  output logic [4:0]  out_hour_of_day,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month_index,
  output logic [7:0]  out_years_since_1900,
  output logic [2:0]  out_weekday,
  output logic [8:0]  out_day_of_year,
  output logic        out_dst_flag
);
  import ep2c_pkg::*;

  // The day count fits in EPOCH_BITS-16 bits since 86400 exceeds 2^16.
  localparam int DAYS_W = EPOCH_BITS - 16;
  localparam int U_W    = (DAYS_W > 18) ? DAYS_W : 18;
  localparam int ADJ_W  = EPOCH_BITS + 2;
  localparam int CNT_W  = $clog2(EPOCH_BITS + 1);

  // Configuration registers.
  logic signed [16:0] zone_r;
  logic               daylight_r;

  // Sequencer and datapath registers.
  ep2c_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [EPOCH_BITS-1:0] t_r, t_nxt;
  logic [16:0]           rem_r, rem_nxt;
  logic [4:0]            hour_r, hour_nxt;
  logic [5:0]            min_r, min_nxt;
  logic [2:0]            w_r, w_nxt;
  logic [3:0]            mon_r, mon_nxt;
  logic [8:0]            yday_r, yday_nxt;
  logic                  dst_r, dst_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] o_sec_r, o_min_r;
  logic [4:0] o_hour_r, o_mday_r;
  logic [3:0] o_mon_r;
  logic [7:0] o_year_r;
  logic [2:0] o_wday_r;
  logic [8:0] o_yday_r;
  logic       o_dst_r;
  logic       out_load;

  // Shared unit and year tracker.
  logic [U_W-1:0] u_a, u_b, u_diff;
  logic           u_ge;
  ep2c_yctl_t     yctl;
  logic [7:0]     year;
  logic           leap;

  // Adjusted and clamped time.
  logic signed [ADJ_W-1:0] adj;
  logic signed [ADJ_W-1:0] adj_max;
  logic [EPOCH_BITS-1:0]   t_sat;

  logic [DAYS_W-1:0] days;
  logic [17:0]       div_part;
  logic [3:0]        wd_part;
  logic [4:0]        mlen;
  logic [3:0]        wsum;
  logic              in_xfer;
  logic              out_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;

  assign days     = t_r[DAYS_W-1:0];
  assign div_part = {rem_r, t_r[EPOCH_BITS-1]};
  assign wd_part  = {w_r, t_r[DAYS_W-1]};
  assign mlen     = month_len(mon_r) + {4'd0, (mon_r == FEBRUARY) && leap};

  // Zone offset and daylight hour are applied in one signed sum; the result
  // is then clamped to the representable range.
  always_comb begin
    adj = $signed(ADJ_W'(in_epoch_time)) - ADJ_W'(zone_r)
        + (daylight_r ? $signed(ADJ_W'(SECS_PER_HOUR)) : $signed(ADJ_W'(0)));
    adj_max = $signed({2'b00, {EPOCH_BITS{1'b1}}});
    if (adj[ADJ_W-1]) begin
      t_sat = '0;
    end else if (adj > adj_max) begin
      t_sat = {EPOCH_BITS{1'b1}};
    end else begin
      t_sat = adj[EPOCH_BITS-1:0];
    end
  end

  // Operand selection for the shared compare-and-subtract unit.
  always_comb begin
    case (state_r)
      S_DIVD: begin
        u_a = U_W'(div_part);
        u_b = U_W'(SECS_PER_DAY);
      end
      S_HOUR: begin
        u_a = U_W'(rem_r);
        u_b = U_W'(SECS_PER_HOUR << cnt_r[2:0]);
      end
      S_MINS: begin
        u_a = U_W'(rem_r);
        u_b = U_W'(SECS_PER_MIN << cnt_r[2:0]);
      end
      S_WDAY: begin
        u_a = U_W'(wd_part);
        u_b = U_W'(DAYS_PER_WEEK);
      end
      S_YEAR: begin
        u_a = U_W'(days);
        u_b = U_W'(DAYS_PER_YEAR) + U_W'(leap);
      end
      S_MONTH: begin
        u_a = U_W'(days);
        u_b = U_W'(mlen);
      end
      default: begin
        u_a = '0;
        u_b = '0;
      end
    endcase
  end

  ep2c_sub #(.W(U_W)) u_sub (
    .a    (u_a),
    .b    (u_b),
    .diff (u_diff),
    .ge   (u_ge)
  );

  ep2c_yr u_yr (
    .clk  (clk),
    .ctl  (yctl),
    .year (year),
    .leap (leap)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    t_nxt     = t_r;
    rem_nxt   = rem_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    w_nxt     = w_r;
    mon_nxt   = mon_r;
    yday_nxt  = yday_r;
    dst_nxt   = dst_r;
    yctl      = '0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          t_nxt     = t_sat;
          rem_nxt   = '0;
          w_nxt     = '0;
          dst_nxt   = daylight_r;
          cnt_nxt   = CNT_W'(EPOCH_BITS - 1);
          yctl.init = 1'b1;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        // Restoring division by 86400: quotient bits shift into t_r.
        rem_nxt = u_ge ? u_diff[16:0] : div_part[16:0];
        t_nxt   = {t_r[EPOCH_BITS-2:0], u_ge};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(4);
          state_nxt = S_HOUR;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_HOUR: begin
        if (u_ge) begin
          rem_nxt = u_diff[16:0];
        end
        hour_nxt = {hour_r[3:0], u_ge};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(5);
          state_nxt = S_MINS;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_MINS: begin
        if (u_ge) begin
          rem_nxt = u_diff[16:0];
        end
        min_nxt = {min_r[4:0], u_ge};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(DAYS_W - 1);
          state_nxt = S_WDAY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_WDAY: begin
        // Day count mod 7, scanning the day count msb first while rotating
        // it so it is back in place when the scan ends.
        w_nxt = u_ge ? u_diff[2:0] : wd_part[2:0];
        t_nxt[DAYS_W-1:0] = {days[DAYS_W-2:0], days[DAYS_W-1]};
        if (cnt_r == '0) begin
          state_nxt = S_YEAR;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_YEAR: begin
        if (u_ge) begin
          t_nxt[DAYS_W-1:0] = u_diff[DAYS_W-1:0];
          yctl.step = 1'b1;
        end else begin
          yday_nxt  = days[8:0];
          mon_nxt   = '0;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if (u_ge && (mon_r != LAST_MONTH)) begin
          t_nxt[DAYS_W-1:0] = u_diff[DAYS_W-1:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_xfer) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign wsum = {1'b0, w_r} + WDAY_BASE;
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      zone_r      <= '0;
      daylight_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ZONE: zone_r     <= $signed(cfg_data);
          CFG_DST:  daylight_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    t_r    <= t_nxt;
    rem_r  <= rem_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    w_r    <= w_nxt;
    mon_r  <= mon_nxt;
    yday_r <= yday_nxt;
    dst_r  <= dst_nxt;
    if (out_load) begin
      o_sec_r  <= rem_r[5:0];
      o_min_r  <= min_r;
      o_hour_r <= hour_r;
      o_mday_r <= days[4:0] + 5'd1;
      o_mon_r  <= mon_r;
      o_year_r <= year;
      o_wday_r <= (wsum >= DAYS_PER_WEEK) ? 3'(wsum - DAYS_PER_WEEK) : wsum[2:0];
      o_yday_r <= yday_r;
      o_dst_r  <= dst_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_second_of_minute = o_sec_r;
  assign out_minute_of_hour   = o_min_r;
  assign out_hour_of_day      = o_hour_r;
  assign out_day_of_month     = o_mday_r;
  assign out_month_index      = o_mon_r;
  assign out_years_since_1900 = o_year_r;
  assign out_weekday          = o_wday_r;
  assign out_day_of_year      = o_yday_r;
  assign out_dst_flag         = o_dst_r;

  // A new result only appears after the sequencer has finished an item.
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result appeared without a finished item");

  // An accepted item always starts the day division.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == S_DIVD)
    else $error("accepted item did not start the division");

  // Delivered time of day is within range.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_sec_r < 6'd60) && (o_min_r < 6'd60) && (o_hour_r < 5'd24))
    else $error("time of day out of range");

  // Delivered date fields are within range.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_mon_r <= LAST_MONTH) && (o_mday_r != 5'd0)
                 && (o_wday_r < 3'd7) && (o_yday_r <= 9'd365))
    else $error("date out of range");

endmodule

/* bench/tb_epoch_seconds_to_calendar_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for epoch_seconds_to_calendar_unit: a calendar predictor,
// in-order result checking, register sweeps and randomized flow control.
// Depends on ep2c_pkg and the unit itself.
module tb_epoch_seconds_to_calendar_unit;

  import ep2c_pkg::*;

  // Indexes past the two registers; the unit must drop writes to them.
  localparam logic [1:0] CFG_UNMAPPED_LO = 2'd2;
  localparam logic [1:0] CFG_UNMAPPED_HI = 2'd3;

  localparam longint MAX_EPOCH  = 64'sh0000_0000_FFFF_FFFF;
  localparam longint DAY_SECS   = 86400;
  localparam longint HOUR_SECS  = 3600;
  localparam longint MIN_SECS   = 60;
  localparam int     FIRST_YEAR = 1970;

  // A long conversion means that nothing moves for a while now and then.
  // The long receiver hold-off below is the longest quiet stretch by far.
  localparam int HOLD_CYCLES  = 1000;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int IDLE_PERCENT = 27;
  localparam int PHASE_ITEMS  = 210;

  // One broken-down calendar time, at the widths of the result ports.
  typedef struct packed {
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic       dst_flag;
  } calendar_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_epoch_time;
  logic        out_valid;
  logic        out_stall;
  calendar_t   got;

  epoch_seconds_to_calendar_unit u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_epoch_time        (in_epoch_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_second_of_minute (got.second_of_minute),
    .out_minute_of_hour   (got.minute_of_hour),
    .out_hour_of_day      (got.hour_of_day),
    .out_day_of_month     (got.day_of_month),
    .out_month_index      (got.month_index),
    .out_years_since_1900 (got.years_since_1900),
    .out_weekday          (got.weekday),
    .out_day_of_year      (got.day_of_year),
    .out_dst_flag         (got.dst_flag)
  );

  // Our own copy of the two registers, updated on every accepted write.
  logic signed [16:0] zone_west;
  logic               dst_on;

  // Calendar times still owed by the unit, oldest first.
  calendar_t calendar_due[$];

  int  errors;
  int  items_sent;
  int  results_checked;
  int  settings_applied;
  int  quiet_cycles;

  // Flow-control knobs. steady turns off random idling on both sides;
  // toggling hold_req asks the receiver for one long hold-off.
  bit  steady;
  bit  hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int leap_year(input int year);
    if (year % 4 != 0) return 0;
    if (year % 100 != 0) return 1;
    if (year % 400 != 0) return 0;
    return 1;
  endfunction

  function automatic int days_in_month(input int mon, input int leap);
    case (mon)
      1:       return 28 + leap;
      3, 5, 8, 10: return 30;
      default: return 31;
    endcase
  endfunction

  // Applies the zone and daylight settings, clamps to the 32-bit range and
  // breaks the result down the way the unit does: whole days, then years
  // walked from 1970, then months walked within the found year.
  function automatic calendar_t compute_calendar(input logic [31:0] epoch);
    longint    adj;
    longint    days;
    longint    secs;
    longint    yday;
    int        year;
    int        mon;
    int        leap;
    calendar_t r;
    adj = longint'({32'd0, epoch}) - longint'(zone_west);
    if (dst_on) adj = adj + HOUR_SECS;
    if (adj < 0) adj = 0;
    if (adj > MAX_EPOCH) adj = MAX_EPOCH;
    days = adj / DAY_SECS;
    secs = adj % DAY_SECS;
    year = FIRST_YEAR;
    while (days >= 365 + leap_year(year)) begin
      days = days - (365 + leap_year(year));
      year++;
    end
    yday = days;
    leap = leap_year(year);
    mon = 0;
    while (mon < 11 && days >= days_in_month(mon, leap)) begin
      days = days - days_in_month(mon, leap);
      mon++;
    end
    r.second_of_minute = 6'((secs % HOUR_SECS) % MIN_SECS);
    r.minute_of_hour   = 6'((secs % HOUR_SECS) / MIN_SECS);
    r.hour_of_day      = 5'(secs / HOUR_SECS);
    r.day_of_month     = 5'(days + 1);
    r.month_index      = 4'(mon);
    r.years_since_1900 = 8'(year - 1900);
    r.weekday          = 3'((adj / DAY_SECS + 4) % 7);
    r.day_of_year      = 9'(yday);
    r.dst_flag         = dst_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Seconds from the epoch to the first of a given month.
  function automatic longint month_start_secs(input int year, input int mon);
    longint days;
    days = 0;
    for (int y = FIRST_YEAR; y < year; y++) days += 365 + leap_year(y);
    for (int m = 0; m < mon; m++) days += days_in_month(m, leap_year(year));
    return days * DAY_SECS;
  endfunction

  // Uniform times in two of five picks, with heavy weight near year and month boundaries
  // and near both ends of the 32-bit range where clamping kicks in.
  function automatic logic [31:0] pick_epoch();
    longint t;
    int     kind;
    kind = $urandom_range(99);
    if (kind < 40) begin
      t = longint'($urandom);
    end else if (kind < 65) begin
      t = month_start_secs($urandom_range(2106, 1970), 0)
          + longint'($urandom_range(200000)) - 100000;
    end else if (kind < 80) begin
      t = month_start_secs($urandom_range(2106, 1970), $urandom_range(11))
          + longint'($urandom_range(172800)) - DAY_SECS;
    end else if (kind < 90) begin
      t = longint'($urandom_range(200000));
    end else begin
      t = MAX_EPOCH - longint'($urandom_range(200000));
    end
    if (t < 0) t = 0;
    if (t > MAX_EPOCH) t = MAX_EPOCH;
    return t[31:0];
  endfunction

  function automatic bit roll_idle();
    return !steady && ($urandom_range(99) < IDLE_PERCENT);
  endfunction

  // Offers one time on the input channel and books its expected calendar
  // time once the transfer happens. Valid is left high afterwards so that
  // back-to-back items keep it asserted without a glitch.
  task automatic send_epoch(input logic [31:0] epoch);
    @(negedge clk);
    while (roll_idle()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_epoch_time <= epoch;
    do @(posedge clk); while (in_stall);
    calendar_due.push_back(compute_calendar(epoch));
    items_sent++;
  endtask

  // Drops valid and waits until every booked result has been delivered.
  // Every item yields a result, so the unit is idle once the queue is empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (calendar_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ZONE: zone_west = data;
      CFG_DST:  dst_on    = data[0];
      default:  ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Writes both registers. The daylight write carries random upper bits,
  // which the unit has to ignore.
  task automatic apply_setting(input logic signed [16:0] zone, input bit dst);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(CFG_ZONE, zone);
    write_reg(CFG_DST, {junk, dst});
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Conversions straight out of reset: no zone, no daylight time.
  task automatic test_reset_settings();
    send_epoch(32'd0);
    send_epoch(32'd86399);
    send_epoch(32'hFFFF_FFFF);
    settle();
  endtask

  // Leap days, the century rule, year ends and the 2038 rollover point.
  task automatic test_calendar_corners();
    apply_setting(17'sd0, 1'b0);
    send_epoch(32'd31535999);    // 1970-12-31 23:59:59
    send_epoch(32'd68169600);    // 1972-02-29
    send_epoch(32'd946684799);   // 1999-12-31 23:59:59
    send_epoch(32'd951782400);   // 2000-02-29, leap by the 400-year rule
    send_epoch(32'd978220800);   // 2000-12-31, day 365 of a leap year
    send_epoch(32'd2147483647);  // 2038-01-19 03:14:07
    send_epoch(32'd4107456000);  // 2100-02-28, century year not leap
    send_epoch(32'd4107542400);  // 2100-03-01
    settle();
  endtask

  // Zone and daylight adjustments, including clamping at both ends and the
  // exact points where clamping starts.
  task automatic test_zone_saturation();
    apply_setting(17'sd43200, 1'b0);
    send_epoch(32'd0);               // far below zero after adjustment
    send_epoch(32'd43199);           // one second below zero
    send_epoch(32'd43200);           // lands exactly on the epoch
    settle();
    apply_setting(-17'sd50400, 1'b1);
    send_epoch(32'hFFFF_FFFF);       // clamps at the top
    send_epoch(32'hFFFF_FFFF - 32'd54000);  // lands exactly on the top
    settle();
    // Field extremes beyond the documented offset range.
    apply_setting(-17'sd65536, 1'b1);
    send_epoch(32'hFFFF_FF00);
    settle();
    apply_setting(17'sd65535, 1'b0);
    send_epoch(32'd65534);
    send_epoch(32'd65535);
    settle();
  endtask

  // Writes to indexes past the register list must leave the settings alone.
  task automatic test_unmapped_index();
    apply_setting(17'sd18000, 1'b1);
    write_reg(CFG_UNMAPPED_LO, 17'h1FFFF);
    write_reg(CFG_UNMAPPED_HI, 17'h00000);
    send_epoch(32'd1000000000);
    send_epoch(32'd0);
    settle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items, so the output register and the datapath both fill and
  // the unit has to push back on its input.
  task automatic test_full_backpressure();
    apply_setting(-17'sd3600, 1'b0);
    steady   = 1'b1;
    hold_req = ~hold_req;
    for (int i = 0; i < 12; i++) send_epoch(pick_epoch());
    steady = 1'b0;
    settle();
  endtask

  // Random times under a series of settings, extremes among them. One
  // phase runs with no idling on either side.
  task automatic test_random_sweep();
    logic signed [16:0] zone;
    bit                 dst;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       begin zone = 17'sd0;      dst = 1'b0; end
        1:       begin zone = -17'sd50400; dst = 1'b1; end
        2:       begin zone = 17'sd43200;  dst = 1'b0; end
        3:       begin zone = 17'sd43200;  dst = 1'b1; end
        4:       begin zone = -17'sd50400; dst = 1'b0; end
        5:       begin zone = 17'($urandom_range(93600)) - 17'sd50400;
                       dst = 1'($urandom); end
        default: begin zone = 17'($urandom); dst = 1'($urandom); end
      endcase
      apply_setting(zone, dst);
      steady = (phase == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) send_epoch(pick_epoch());
      steady = 1'b0;
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int seen, input int want);
    if (seen != want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_checked, name, seen, want));
  endtask

  // Random stall at each falling edge, or a solid hold-off when one has
  // been requested. The hold-off length is counted here.
  initial begin : receiver
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= roll_idle();
      end
    end
  end

  // Compares each delivered calendar time with the oldest one booked.
  always @(posedge clk) begin
    calendar_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (calendar_due.size() == 0) begin
        report_mismatch("result transfer with nothing outstanding");
      end else begin
        want = calendar_due.pop_front();
        check_field("second_of_minute", got.second_of_minute, want.second_of_minute);
        check_field("minute_of_hour", got.minute_of_hour, want.minute_of_hour);
        check_field("hour_of_day", got.hour_of_day, want.hour_of_day);
        check_field("day_of_month", got.day_of_month, want.day_of_month);
        check_field("month_index", got.month_index, want.month_index);
        check_field("years_since_1900", got.years_since_1900, want.years_since_1900);
        check_field("weekday", got.weekday, want.weekday);
        check_field("day_of_year", got.day_of_year, want.day_of_year);
        check_field("dst_flag", got.dst_flag, want.dst_flag);
      end
      results_checked++;
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, calendar_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_epoch_time    = '0;
    zone_west        = '0;
    dst_on           = 1'b0;
    errors           = 0;
    items_sent       = 0;
    results_checked  = 0;
    settings_applied = 0;
    quiet_cycles     = 0;
    steady           = 1'b0;
    hold_req         = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_settings();
    test_calendar_corners();
    test_zone_saturation();
    test_unmapped_index();
    test_full_backpressure();
    test_random_sweep();

    // Everything has been accepted; let any stray result show up.
    while (calendar_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d times and checked %0d calendar conversions under %0d settings,",
             items_sent, results_checked, settings_applied);
    $display("covering clamping at both ends, leap and century years and full back-pressure.");
    if (errors == 0 && calendar_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
